// File: sv/pairwise_gravity_force_assert.svh
// Assertion macros for the pairwise gravity force block.
`ifndef PAIRWISE_GRAVITY_FORCE_ASSERT_SVH
`define PAIRWISE_GRAVITY_FORCE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle or fixed-delay implication, disabled while in reset.
`define PGF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("pgf assertion failed");
// Next-cycle implication, disabled while in reset.
`define PGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("pgf assertion failed");
`else
`define PGF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/pgf_pkg.sv
// Shared types, widths and constants of the pairwise gravity force block.
`default_nettype none
package pgf_pkg;

  localparam int COORD_W  = 32;   // Q16.16 position / force code
  localparam int MASS_W   = 32;   // unsigned Q16.16 mass / register
  localparam int DIFF_W   = 33;   // exact coordinate difference
  localparam int MAG_W    = 32;   // magnitude of a difference
  localparam int D2_W     = 65;   // exact squared distance
  localparam int ROOT_W   = 33;   // floor(sqrt(D2))
  localparam int N_W      = 96;   // G * m1 * m2
  localparam int PROD_W   = 128;  // T * |delta|
  localparam int FRAC_W   = 16;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [MASS_W-1:0] G_RESET      = 32'h0001_0000;
  localparam logic [MASS_W-1:0] MIN_D2_RESET = 32'h000A_0000;

  typedef enum logic [0:0] {
    REG_GRAVITY = 1'b0,
    REG_MIN_D2  = 1'b1
  } pgf_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] self_x;
    logic signed [COORD_W-1:0] self_y;
    logic signed [COORD_W-1:0] other_x;
    logic signed [COORD_W-1:0] other_y;
    logic [MASS_W-1:0]         self_mass;
    logic [MASS_W-1:0]         other_mass;
  } pgf_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] force_x;
    logic signed [COORD_W-1:0] force_y;
    logic                      too_close;
    logic                      saturated;
  } pgf_out_t;

  // Sideband carried through the square root pipeline.
  typedef struct packed {
    logic [N_W-1:0]   n;
    logic             tc;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [D2_W-1:0]  d2;
  } pgf_sq_side_t;

  // Sideband carried through the strength divider.
  typedef struct packed {
    logic             tc;
    logic             sx;
    logic             sy;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [D2_W-1:0]  d2;
  } pgf_d1_side_t;

  // Sideband of the x component divider.
  typedef struct packed {
    logic tc;
    logic sx;
    logic ov;
  } pgf_dx_side_t;

  // Sideband of the y component divider.
  typedef struct packed {
    logic sy;
    logic ov;
  } pgf_dy_side_t;

  // Register stages from accept to result strobe.
  localparam int FRONT_STAGES = 3;
  localparam int MID_STAGES   = 3;
  localparam int LATENCY = FRONT_STAGES + ROOT_W + N_W + MID_STAGES + COORD_W + 1;

endpackage
`default_nettype wire

// File: sv/pgf_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module pgf_isqrt
  import pgf_pkg::*;
#(
  parameter int RT_W   = ROOT_W,
  parameter int SIDE_W = $bits(pgf_sq_side_t)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  input  wire logic [2*RT_W-1:0]   in_rad,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_vld,
  output logic [RT_W-1:0]          out_root,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int REM_W = RT_W + 3;

  logic              vld_r   [RT_W];
  logic [REM_W-1:0]  rem_r   [RT_W];
  logic [REM_W-1:0]  rem_nxt [RT_W];
  logic [RT_W-1:0]   root_r  [RT_W];
  logic [RT_W-1:0]   root_nxt[RT_W];
  logic [2*RT_W-1:0] rad_r   [RT_W];
  logic [2*RT_W-1:0] rad_nxt [RT_W];
  logic [SIDE_W-1:0] side_r  [RT_W];

  always_comb begin
    logic [REM_W-1:0]  s_rem;
    logic [RT_W-1:0]   s_root;
    logic [2*RT_W-1:0] s_rad;
    logic [REM_W-1:0]  t;
    logic [REM_W-1:0]  trial;
    for (int k = 0; k < RT_W; k++) begin
      if (k == 0) begin
        s_rem  = '0;
        s_root = '0;
        s_rad  = in_rad;
      end else begin
        s_rem  = rem_r[k-1];
        s_root = root_r[k-1];
        s_rad  = rad_r[k-1];
      end
      t     = {s_rem[REM_W-3:0], s_rad[2*RT_W-1 -: 2]};
      trial = {1'b0, s_root, 2'b01};
      if (t >= trial) begin
        rem_nxt[k]  = t - trial;
        root_nxt[k] = {s_root[RT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = t;
        root_nxt[k] = {s_root[RT_W-2:0], 1'b0};
      end
      rad_nxt[k] = {s_rad[2*RT_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < RT_W; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < RT_W; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < RT_W; k++) begin
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
      rad_r[k]  <= rad_nxt[k];
    end
    side_r[0] <= in_side;
    for (int k = 1; k < RT_W; k++) side_r[k] <= side_r[k-1];
  end

  assign out_vld  = vld_r[RT_W-1];
  assign out_root = root_r[RT_W-1];
  assign out_side = side_r[RT_W-1];

endmodule
`default_nettype wire

// File: sv/pgf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module pgf_div
  import pgf_pkg::*;
#(
  parameter int DEN_W  = ROOT_W,
  parameter int QUO_W  = N_W,
  parameter int SIDE_W = $bits(pgf_d1_side_t)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_vld,
  input  wire logic [DEN_W-1:0]  in_rem,   // partial remainder, below in_den
  input  wire logic [QUO_W-1:0]  in_num,   // dividend bits still to bring down
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_vld,
  output logic [QUO_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  logic              vld_r  [QUO_W];
  logic [DEN_W-1:0]  rem_r  [QUO_W];
  logic [DEN_W-1:0]  rem_nxt[QUO_W];
  logic [QUO_W-1:0]  nq_r   [QUO_W];
  logic [QUO_W-1:0]  nq_nxt [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  always_comb begin
    logic [DEN_W-1:0] s_rem;
    logic [QUO_W-1:0] s_nq;
    logic [DEN_W-1:0] s_den;
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   diff;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        s_rem = in_rem;
        s_nq  = in_num;
        s_den = in_den;
      end else begin
        s_rem = rem_r[k-1];
        s_nq  = nq_r[k-1];
        s_den = den_r[k-1];
      end
      t    = {s_rem, s_nq[QUO_W-1]};
      diff = t - {1'b0, s_den};
      if (t >= {1'b0, s_den}) begin
        rem_nxt[k] = diff[DEN_W-1:0];
        nq_nxt[k]  = {s_nq[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = t[DEN_W-1:0];
        nq_nxt[k]  = {s_nq[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
      for (int k = 1; k < QUO_W; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      nq_r[k]  <= nq_nxt[k];
    end
    den_r[0]  <= in_den;
    side_r[0] <= in_side;
    for (int k = 1; k < QUO_W; k++) begin
      den_r[k]  <= den_r[k-1];
      side_r[k] <= side_r[k-1];
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = nq_r[QUO_W-1];
  assign out_side = side_r[QUO_W-1];

endmodule
`default_nettype wire

// File: sv/pairwise_gravity_force.sv
// Top level of the pairwise gravity force pipeline.
//
//   channel   ports                          handshake
//   input     start, busy, in_item           taken when start & !busy
//   result    out_strobe, out_item           one cycle per item, no back-pressure
//   config    psel/penable/pwrite/paddr/...  APB write, pready tied high
//
// Throughput: one body pair per cycle; busy stays low.
// Depth from accept to strobe: the bit-per-stage square root (33 stages),
// the strength divider (96 stages) and the component dividers (32 stages),
// plus six arithmetic stages and the output register.
// Reset clears the valid bits and loads G = 1.0 and minimum squared distance 10.0.
// The receiver cannot stall, so the pipeline simply advances every cycle.
`default_nettype none
`include "pairwise_gravity_force_assert.svh"
module pairwise_gravity_force
  import pgf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              start,
  output logic                   busy,
  input  wire pgf_in_t           in_item,
  // result channel
  output logic                   out_strobe,
  output pgf_out_t               out_item,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  // Result of a too-close pair: no force, flag set, no clamp.
  localparam pgf_out_t TC_ITEM = '{force_x: '0, force_y: '0, too_close: 1'b1,
                                   saturated: 1'b0};

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MASS_W-1:0] g_r;
  logic [MASS_W-1:0] min_d2_r;
  pgf_reg_t          cfg_sel;

  assign cfg_sel = pgf_reg_t'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r      <= G_RESET;
      min_d2_r <= MIN_D2_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        REG_GRAVITY: g_r      <= pwdata;
        REG_MIN_D2:  min_d2_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GRAVITY: prdata = g_r;
      REG_MIN_D2:  prdata = min_d2_r;
      default:     prdata = '0;
    endcase
  end

  // The pipeline never holds off an item.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: distance vector and G * self_mass
  // ---------------------------------------------------------------------
  logic                s1_vld_r;
  logic [DIFF_W-1:0]   s1_dx_r, s1_dy_r;
  logic [2*MASS_W-1:0] s1_gm_r;
  logic [MASS_W-1:0]   s1_om_r;
  logic [DIFF_W-1:0]   s1_dx_nxt, s1_dy_nxt;
  logic [2*MASS_W-1:0] s1_gm_nxt;

  assign s1_dx_nxt = {in_item.other_x[COORD_W-1], in_item.other_x}
                   - {in_item.self_x[COORD_W-1], in_item.self_x};
  assign s1_dy_nxt = {in_item.other_y[COORD_W-1], in_item.other_y}
                   - {in_item.self_y[COORD_W-1], in_item.self_y};
  assign s1_gm_nxt = g_r * in_item.self_mass;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_dx_r <= s1_dx_nxt;
    s1_dy_r <= s1_dy_nxt;
    s1_gm_r <= s1_gm_nxt;
    s1_om_r <= in_item.other_mass;
  end

  // ---------------------------------------------------------------------
  // Stage 2: magnitudes, squares and the two halves of G*m1*m2
  // ---------------------------------------------------------------------
  logic                s2_vld_r;
  logic                s2_sx_r, s2_sy_r;
  logic [MAG_W-1:0]    s2_ax_r, s2_ay_r;
  logic [2*MAG_W-1:0]  s2_sqx_r, s2_sqy_r;
  logic [2*MASS_W-1:0] s2_nlo_r, s2_nhi_r;
  logic [DIFF_W-1:0]   s2_negx, s2_negy;
  logic [MAG_W-1:0]    s2_ax_nxt, s2_ay_nxt;

  assign s2_negx   = DIFF_W'(0) - s1_dx_r;
  assign s2_negy   = DIFF_W'(0) - s1_dy_r;
  assign s2_ax_nxt = s1_dx_r[DIFF_W-1] ? s2_negx[MAG_W-1:0] : s1_dx_r[MAG_W-1:0];
  assign s2_ay_nxt = s1_dy_r[DIFF_W-1] ? s2_negy[MAG_W-1:0] : s1_dy_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else        s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    s2_sx_r  <= s1_dx_r[DIFF_W-1];
    s2_sy_r  <= s1_dy_r[DIFF_W-1];
    s2_ax_r  <= s2_ax_nxt;
    s2_ay_r  <= s2_ay_nxt;
    s2_sqx_r <= s2_ax_nxt * s2_ax_nxt;
    s2_sqy_r <= s2_ay_nxt * s2_ay_nxt;
    s2_nlo_r <= s1_gm_r[MASS_W-1:0] * s1_om_r;
    s2_nhi_r <= s1_gm_r[2*MASS_W-1:MASS_W] * s1_om_r;
  end

  // ---------------------------------------------------------------------
  // Stage 3: squared distance, numerator, too-close decision
  // ---------------------------------------------------------------------
  logic              s3_vld_r;
  pgf_sq_side_t      s3_r;
  logic [D2_W-1:0]   s3_d2_nxt;
  logic [N_W-1:0]    s3_n_nxt;
  logic [D2_W-1:0]   s3_lim;

  assign s3_d2_nxt = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
  assign s3_n_nxt  = {32'd0, s2_nlo_r} + {s2_nhi_r, 32'd0};
  assign s3_lim    = {{(D2_W-MASS_W-FRAC_W){1'b0}}, min_d2_r, {FRAC_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else        s3_vld_r <= s2_vld_r;
  end

  // Coincident bodies have no direction: treat them as too close.
  always_ff @(posedge clk) begin
    s3_r.n  <= s3_n_nxt;
    s3_r.tc <= (s3_d2_nxt == '0) || (s3_d2_nxt < s3_lim);
    s3_r.sx <= s2_sx_r;
    s3_r.sy <= s2_sy_r;
    s3_r.ax <= s2_ax_r;
    s3_r.ay <= s2_ay_r;
    s3_r.d2 <= s3_d2_nxt;
  end

  // ---------------------------------------------------------------------
  // Distance d = floor(sqrt(D2))
  // ---------------------------------------------------------------------
  logic                              sq_vld;
  logic [ROOT_W-1:0]                 sq_root;
  logic [$bits(pgf_sq_side_t)-1:0]   sq_side_v;
  pgf_sq_side_t                      sq_side;

  pgf_isqrt #(
    .RT_W   (ROOT_W),
    .SIDE_W ($bits(pgf_sq_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s3_vld_r),
    .in_rad   ({1'b0, s3_r.d2}),
    .in_side  (s3_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side_v)
  );

  assign sq_side = pgf_sq_side_t'(sq_side_v);

  // ---------------------------------------------------------------------
  // Strength T = floor(N / d)
  // ---------------------------------------------------------------------
  pgf_d1_side_t                    d1_in_side;
  logic                            d1_vld;
  logic [N_W-1:0]                  d1_t;
  logic [$bits(pgf_d1_side_t)-1:0] d1_side_v;
  pgf_d1_side_t                    d1_side;

  always_comb begin
    d1_in_side.tc = sq_side.tc;
    d1_in_side.sx = sq_side.sx;
    d1_in_side.sy = sq_side.sy;
    d1_in_side.ax = sq_side.ax;
    d1_in_side.ay = sq_side.ay;
    d1_in_side.d2 = sq_side.d2;
  end

  // d is zero only for too-close items, whose quotient is discarded.
  pgf_div #(
    .DEN_W  (ROOT_W),
    .QUO_W  (N_W),
    .SIDE_W ($bits(pgf_d1_side_t))
  ) u_div_strength (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_rem   ({ROOT_W{1'b0}}),
    .in_num   (sq_side.n),
    .in_den   (sq_root),
    .in_side  (d1_in_side),
    .out_vld  (d1_vld),
    .out_quo  (d1_t),
    .out_side (d1_side_v)
  );

  assign d1_side = pgf_d1_side_t'(d1_side_v);

  // ---------------------------------------------------------------------
  // Stage 4: partial products of T * |delta|
  // ---------------------------------------------------------------------
  logic               s4_vld_r;
  logic               s4_tc_r, s4_sx_r, s4_sy_r;
  logic [D2_W-1:0]    s4_d2_r;
  logic [2*MAG_W-1:0] s4_x0_r, s4_x1_r, s4_x2_r;
  logic [2*MAG_W-1:0] s4_y0_r, s4_y1_r, s4_y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else        s4_vld_r <= d1_vld;
  end

  always_ff @(posedge clk) begin
    s4_tc_r <= d1_side.tc;
    s4_sx_r <= d1_side.sx;
    s4_sy_r <= d1_side.sy;
    s4_d2_r <= d1_side.d2;
    s4_x0_r <= d1_t[31:0]  * d1_side.ax;
    s4_x1_r <= d1_t[63:32] * d1_side.ax;
    s4_x2_r <= d1_t[95:64] * d1_side.ax;
    s4_y0_r <= d1_t[31:0]  * d1_side.ay;
    s4_y1_r <= d1_t[63:32] * d1_side.ay;
    s4_y2_r <= d1_t[95:64] * d1_side.ay;
  end

  // ---------------------------------------------------------------------
  // Stage 5: sum the partial products
  // ---------------------------------------------------------------------
  logic              s5_vld_r;
  logic              s5_tc_r, s5_sx_r, s5_sy_r;
  logic [D2_W-1:0]   s5_d2_r;
  logic [PROD_W-1:0] s5_px_r, s5_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else        s5_vld_r <= s4_vld_r;
  end

  always_ff @(posedge clk) begin
    s5_tc_r <= s4_tc_r;
    s5_sx_r <= s4_sx_r;
    s5_sy_r <= s4_sy_r;
    s5_d2_r <= s4_d2_r;
    s5_px_r <= {64'd0, s4_x0_r} + {32'd0, s4_x1_r, 32'd0} + {s4_x2_r, 64'd0};
    s5_py_r <= {64'd0, s4_y0_r} + {32'd0, s4_y1_r, 32'd0} + {s4_y2_r, 64'd0};
  end

  // ---------------------------------------------------------------------
  // Stage 6: overflow check. The quotient reaches 2^32 exactly when the
  // product's upper 96 bits reach D2; otherwise those bits are the first
  // partial remainder and only 32 quotient bits are left to find.
  // ---------------------------------------------------------------------
  logic              s6_vld_r;
  pgf_dx_side_t      s6_xs_r;
  pgf_dy_side_t      s6_ys_r;
  logic [D2_W-1:0]   s6_d2_r;
  logic [PROD_W-1:0] s6_px_r, s6_py_r;
  logic [PROD_W-COORD_W-1:0] s6_d2_ext;

  assign s6_d2_ext = {{(PROD_W-COORD_W-D2_W){1'b0}}, s5_d2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) s6_vld_r <= 1'b0;
    else        s6_vld_r <= s5_vld_r;
  end

  always_ff @(posedge clk) begin
    s6_xs_r.tc <= s5_tc_r;
    s6_xs_r.sx <= s5_sx_r;
    s6_xs_r.ov <= s5_px_r[PROD_W-1:COORD_W] >= s6_d2_ext;
    s6_ys_r.sy <= s5_sy_r;
    s6_ys_r.ov <= s5_py_r[PROD_W-1:COORD_W] >= s6_d2_ext;
    s6_d2_r    <= s5_d2_r;
    s6_px_r    <= s5_px_r;
    s6_py_r    <= s5_py_r;
  end

  // ---------------------------------------------------------------------
  // Component dividers: low 32 quotient bits of P / D2
  // ---------------------------------------------------------------------
  logic                            divx_vld, divy_vld;
  logic [COORD_W-1:0]              divx_q, divy_q;
  logic [$bits(pgf_dx_side_t)-1:0] divx_side_v;
  logic [$bits(pgf_dy_side_t)-1:0] divy_side_v;
  pgf_dx_side_t                    divx_side;
  pgf_dy_side_t                    divy_side;

  pgf_div #(
    .DEN_W  (D2_W),
    .QUO_W  (COORD_W),
    .SIDE_W ($bits(pgf_dx_side_t))
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s6_vld_r),
    .in_rem   (s6_px_r[COORD_W+D2_W-1:COORD_W]),
    .in_num   (s6_px_r[COORD_W-1:0]),
    .in_den   (s6_d2_r),
    .in_side  (s6_xs_r),
    .out_vld  (divx_vld),
    .out_quo  (divx_q),
    .out_side (divx_side_v)
  );

  pgf_div #(
    .DEN_W  (D2_W),
    .QUO_W  (COORD_W),
    .SIDE_W ($bits(pgf_dy_side_t))
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s6_vld_r),
    .in_rem   (s6_py_r[COORD_W+D2_W-1:COORD_W]),
    .in_num   (s6_py_r[COORD_W-1:0]),
    .in_den   (s6_d2_r),
    .in_side  (s6_ys_r),
    .out_vld  (divy_vld),
    .out_quo  (divy_q),
    .out_side (divy_side_v)
  );

  assign divx_side = pgf_dx_side_t'(divx_side_v);
  assign divy_side = pgf_dy_side_t'(divy_side_v);

  // ---------------------------------------------------------------------
  // Output: clamp, apply sign, drop force for too-close pairs
  // ---------------------------------------------------------------------
  // Returns {clamped, signed force}.
  function automatic logic [COORD_W:0] sat_force(input logic neg, input logic ov,
                                                 input logic [COORD_W-1:0] q);
    logic [COORD_W-1:0] lim;
    logic               sat;
    logic [COORD_W-1:0] mag;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat = ov || (q > lim);
    mag = sat ? lim : q;
    return {sat, (neg ? (COORD_W'(0) - mag) : mag)};
  endfunction

  logic              out_strobe_r;
  pgf_out_t          out_item_r;
  pgf_out_t          out_item_nxt;
  logic [COORD_W:0]  fx, fy;

  assign fx = sat_force(divx_side.sx, divx_side.ov, divx_q);
  assign fy = sat_force(divy_side.sy, divy_side.ov, divy_q);

  always_comb begin
    if (divx_side.tc) begin
      out_item_nxt.force_x   = '0;
      out_item_nxt.force_y   = '0;
      out_item_nxt.too_close = 1'b1;
      out_item_nxt.saturated = 1'b0;
    end else begin
      out_item_nxt.force_x   = fx[COORD_W-1:0];
      out_item_nxt.force_y   = fy[COORD_W-1:0];
      out_item_nxt.too_close = 1'b0;
      out_item_nxt.saturated = fx[COORD_W] || fy[COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= divx_vld;
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `PGF_ASSERT_IMPLY(a_fixed_latency, clk, rst_n, start && !busy, ##LATENCY out_strobe)
  `PGF_ASSERT_IMPLY(a_lanes_in_step, clk, rst_n, divx_vld || divy_vld, divx_vld && divy_vld)
  `PGF_ASSERT_IMPLY(a_close_is_zero, clk, rst_n, out_strobe && out_item.too_close, out_item == TC_ITEM)
  `PGF_ASSERT_NEXT(a_div_to_strobe, clk, rst_n, divx_vld, out_strobe)

endmodule
`default_nettype wire
